// ===== hw/rtl/mts_pkg.sv =====
// shared constants and types for the min tracking stack
package mts_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int VALUE_W     = 32;
    localparam int OCC_W       = 7;

    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [1:0]        t_mode;
    typedef logic [1:0]        t_status;

    localparam t_mode MODE_PUSH  = 2'd0;
    localparam t_mode MODE_POP   = 2'd1;
    localparam t_mode MODE_QUERY = 2'd2;

    localparam t_status STATUS_OK        = 2'd0;
    localparam t_status STATUS_OVERFLOW  = 2'd1;
    localparam t_status STATUS_UNDERFLOW = 2'd2;

endpackage

// ===== hw/rtl/mts_ram.sv =====
// generic single write, single read ram with registered read data
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/min_tracking_stack_unit.sv =====
// min tracking stack: bounded signed stack that reports its running minimum
// ops: push, query and rejected ops go S_IDLE, S_RESP, output register; a successful pop
//   also passes S_READ for the refill read of the value and minima rams
// S_RESP holds while the output word is not taken; no new word is taken until the last result is registered
// reset: i_rst_n synchronous active low, clears both counts and the control state;
//   ram contents stay undefined, only entries below the counts are ever reported
module min_tracking_stack_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] push_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [31:0] top_value, [63:32] min_value,
                                        // [70:64] occupancy, [71] is_empty
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RESP
    } t_state;

    // control and cached stack tops
    t_state              r_state, n_state;
    mts_pkg::t_cnt       r_count, n_count;
    mts_pkg::t_cnt       r_mcount, n_mcount;
    logic signed [31:0]  r_vtop, n_vtop;
    logic signed [31:0]  r_mtop, n_mtop;
    mts_pkg::t_status    r_status, n_status;

    // output register
    logic                r_otvalid, n_otvalid;
    logic [71:0]         r_odata, n_odata;
    logic [1:0]          r_ouser, n_ouser;

    // ram ports
    logic                v_we, m_we;
    mts_pkg::t_addr      v_waddr, m_waddr, v_raddr, m_raddr;
    logic [31:0]         v_rdata, m_rdata;
    logic [31:0]         wr_value;

    logic                s_accept;
    logic                min_pop;
    logic signed [31:0]  in_value;
    logic signed [31:0]  top_out, min_out;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_value      = $signed(s_axis_tdata);
    assign wr_value      = s_axis_tdata;

    // value stack entries, one per stored value
    mts_ram #(
        .WIDTH (mts_pkg::VALUE_W),
        .DEPTH (mts_pkg::STACK_DEPTH)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (wr_value),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    // running minima stack
    mts_ram #(
        .WIDTH (mts_pkg::VALUE_W),
        .DEPTH (mts_pkg::STACK_DEPTH)
    ) u_minima_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (wr_value),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    // reported fields, zero when the stack is empty
    assign top_out = (r_count != '0) ? r_vtop : '0;
    assign min_out = ((r_count != '0) && (r_mcount != '0)) ? r_mtop : '0;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_mcount  = r_mcount;
        n_vtop    = r_vtop;
        n_mtop    = r_mtop;
        n_status  = r_status;
        n_otvalid = r_otvalid && !m_axis_tready;
        n_odata   = r_odata;
        n_ouser   = r_ouser;
        v_we      = 1'b0;
        m_we      = 1'b0;
        v_waddr   = mts_pkg::t_addr'(r_count);
        m_waddr   = mts_pkg::t_addr'(r_mcount);
        min_pop   = (r_mcount != '0) && (r_mtop == r_vtop);

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_status = mts_pkg::STATUS_OK;
                    n_state  = S_RESP;
                    case (s_axis_tuser)
                        mts_pkg::MODE_PUSH: begin
                            if (r_count == mts_pkg::t_cnt'(mts_pkg::STACK_DEPTH)) begin
                                n_status = mts_pkg::STATUS_OVERFLOW;
                            end else begin
                                v_we    = 1'b1;
                                n_vtop  = in_value;
                                n_count = r_count + mts_pkg::t_cnt'(1);
                                // minima count never exceeds the value count,
                                // so there is always room here
                                if ((r_mcount == '0) || (in_value <= r_mtop)) begin
                                    m_we     = 1'b1;
                                    n_mtop   = in_value;
                                    n_mcount = r_mcount + mts_pkg::t_cnt'(1);
                                end
                            end
                        end
                        mts_pkg::MODE_POP: begin
                            if (r_count == '0) begin
                                n_status = mts_pkg::STATUS_UNDERFLOW;
                            end else begin
                                n_count = r_count - mts_pkg::t_cnt'(1);
                                if (min_pop) begin
                                    n_mcount = r_mcount - mts_pkg::t_cnt'(1);
                                end
                                // new tops come back from the rams next cycle
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            // query and the unused code change nothing
                        end
                    endcase
                end
            end
            S_READ: begin
                n_vtop  = $signed(v_rdata);
                n_mtop  = $signed(m_rdata);
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_otvalid || m_axis_tready) begin
                    n_otvalid = 1'b1;
                    n_odata   = {(r_count == '0), mts_pkg::OCC_W'(r_count), min_out, top_out};
                    n_ouser   = r_status;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // read addresses of the new tops after a pop
    assign v_raddr = mts_pkg::t_addr'(n_count - mts_pkg::t_cnt'(1));
    assign m_raddr = mts_pkg::t_addr'(n_mcount - mts_pkg::t_cnt'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_mcount  <= '0;
            r_status  <= mts_pkg::STATUS_OK;
            r_otvalid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_mcount  <= n_mcount;
            r_status  <= n_status;
            r_otvalid <= n_otvalid;
        end
        r_vtop  <= n_vtop;
        r_mtop  <= n_mtop;
        r_odata <= n_odata;
        r_ouser <= n_ouser;
    end

    assign m_axis_tvalid = r_otvalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

`ifndef NO_ASSERTIONS
    // minima stack never holds more entries than the value stack
    a_mcount_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mcount <= r_count)
        else $error("minima count above value count");

    // count stays within the stack depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mts_pkg::t_cnt'(mts_pkg::STACK_DEPTH))
        else $error("value count beyond depth");

    // a successful pop always refills the tops from the rams
    a_pop_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (s_axis_tuser == mts_pkg::MODE_POP) && (r_count != '0))
        |=> (r_state == S_READ))
        else $error("pop did not go through the ram read");

    // a push on a full stack leaves the count alone
    a_overflow_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (s_axis_tuser == mts_pkg::MODE_PUSH)
         && (r_count == mts_pkg::t_cnt'(mts_pkg::STACK_DEPTH)))
        |=> ($stable(r_count) && (r_status == mts_pkg::STATUS_OVERFLOW)))
        else $error("overflow push changed the stack");
`endif

endmodule
